>>> rtl/core/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and codes shared by the first-fit block allocator modules.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int unsigned FIELD_W = 12;

  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_NO_FIT = 1'b1;

  typedef enum logic [1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_FREE   = 2'd1,
    FUNC_REINIT = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef struct packed {
    func_e                func;
    logic [FIELD_W-1:0]   req_size;
    logic [FIELD_W-1:0]   free_addr;
  } in_t;

  typedef struct packed {
    logic                 status;
    logic [FIELD_W-1:0]   addr;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_WR_TAIL,
    ST_WR_HEAD,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic advance;
    logic capture_ok;
    logic capture_fail;
    logic wr_tail;
    logic wr_head;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic fit;
    logic split;
    logic more;
  } stat_t;

endpackage

>>> rtl/core/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer for the header walk, block update and result handoff.
// ----------------------------------------------------------------------------
module ffba_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ffba_pkg::func_e func_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  ffba_pkg::stat_t stat_i,
  output ffba_pkg::cmd_t  cmd_o
);

  ffba_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             slot_free;

  assign accept     = in_valid_i && (state_q == ffba_pkg::ST_IDLE);
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ffba_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ffba_pkg::ST_IDLE: begin
        if (accept) begin
          if (func_i == ffba_pkg::FUNC_ALLOC) begin
            state_d = ffba_pkg::ST_WALK_RD;
          end else begin
            state_d = ffba_pkg::ST_FINISH;
          end
        end
      end
      ffba_pkg::ST_WALK_RD: state_d = ffba_pkg::ST_WALK_CHK;
      ffba_pkg::ST_WALK_CHK: begin
        if (stat_i.fit) begin
          state_d = stat_i.split ? ffba_pkg::ST_WR_TAIL : ffba_pkg::ST_WR_HEAD;
        end else if (stat_i.more) begin
          state_d = ffba_pkg::ST_WALK_RD;
        end else begin
          state_d = ffba_pkg::ST_FINISH;
        end
      end
      ffba_pkg::ST_WR_TAIL: state_d = ffba_pkg::ST_WR_HEAD;
      ffba_pkg::ST_WR_HEAD: state_d = ffba_pkg::ST_FINISH;
      ffba_pkg::ST_FINISH: begin
        if (slot_free) begin
          state_d = ffba_pkg::ST_IDLE;
        end
      end
      default: state_d = ffba_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ffba_pkg::ST_IDLE:     cmd_o.accept = accept;
      ffba_pkg::ST_WALK_RD:  cmd_o.rd_en  = 1'b1;
      ffba_pkg::ST_WALK_CHK: begin
        cmd_o.capture_ok   = stat_i.fit;
        cmd_o.advance      = !stat_i.fit && stat_i.more;
        cmd_o.capture_fail = !stat_i.fit && !stat_i.more;
      end
      ffba_pkg::ST_WR_TAIL:  cmd_o.wr_tail  = 1'b1;
      ffba_pkg::ST_WR_HEAD:  cmd_o.wr_head  = 1'b1;
      ffba_pkg::ST_FINISH:   cmd_o.out_load = slot_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffba_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/core/ffba_datapath.sv
// ----------------------------------------------------------------------------
// ffba_datapath
// Header store, walk position, fit and split arithmetic, result registers.
// ----------------------------------------------------------------------------
module ffba_datapath #(
  parameter int unsigned ARENA_BYTES  = 4096,
  parameter int unsigned HEADER_BYTES = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ffba_pkg::in_t   in_data_i,
  input  ffba_pkg::cmd_t  cmd_i,
  output ffba_pkg::stat_t stat_o,
  output ffba_pkg::out_t  out_data_o
);

  localparam int unsigned AW = $clog2(ARENA_BYTES);
  localparam int unsigned LW = AW;
  localparam int unsigned CW = ((AW > ffba_pkg::FIELD_W) ? AW : ffba_pkg::FIELD_W) + 3;

  localparam logic [CW-1:0] HdrW   = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] ArenaW = CW'(ARENA_BYTES);
  localparam logic [LW-1:0] FullLen = LW'(ARENA_BYTES - HEADER_BYTES);

  logic [LW-1:0] len_mem  [ARENA_BYTES];
  logic          free_mem [ARENA_BYTES];

  logic [AW-1:0]               pos_q;
  logic [LW-1:0]               len0_q;
  logic                        free0_q;
  logic [LW-1:0]               len_rd_q;
  logic                        free_rd_q;
  logic [ffba_pkg::FIELD_W-1:0] want_q;
  ffba_pkg::out_t              res_q;
  ffba_pkg::out_t              out_q;

  logic [LW-1:0] rd_len;
  logic          rd_free;
  logic [CW-1:0] pos_w, len_w, want_w, tail_w, next_w, fa_w, hdr_w;
  logic          tail_in, free_ok, do_free;
  logic [AW-1:0] tail_idx, hdr_idx;

  logic          len_we, free_we, free_wdata;
  logic [AW-1:0] len_waddr, free_waddr;
  logic [LW-1:0] len_wdata;

  assign rd_len  = (pos_q == '0) ? len0_q  : len_rd_q;
  assign rd_free = (pos_q == '0) ? free0_q : free_rd_q;

  assign pos_w  = CW'(pos_q);
  assign len_w  = CW'(rd_len);
  assign want_w = CW'(want_q);
  assign tail_w = pos_w + HdrW + want_w;
  assign next_w = pos_w + HdrW + len_w;
  assign tail_in  = tail_w < ArenaW;
  assign tail_idx = tail_w[AW-1:0];

  assign stat_o.fit   = rd_free && (len_w >= want_w);
  assign stat_o.split = len_w > (want_w + HdrW);
  assign stat_o.more  = (next_w + HdrW) <= ArenaW;

  assign fa_w    = CW'(in_data_i.free_addr);
  assign hdr_w   = fa_w - HdrW;
  assign free_ok = (fa_w >= HdrW) && (hdr_w < ArenaW);
  assign hdr_idx = hdr_w[AW-1:0];
  assign do_free = cmd_i.accept && (in_data_i.func == ffba_pkg::FUNC_FREE) && free_ok;

  always_comb begin
    len_we     = (cmd_i.wr_tail && tail_in) || (cmd_i.wr_head && stat_o.split);
    len_waddr  = cmd_i.wr_tail ? tail_idx : pos_q;
    len_wdata  = cmd_i.wr_tail ? LW'(len_w - want_w - HdrW) : LW'(want_w);
    free_we    = (cmd_i.wr_tail && tail_in) || cmd_i.wr_head || do_free;
    free_wdata = !cmd_i.wr_head;
    priority if (cmd_i.wr_tail) begin
      free_waddr = tail_idx;
    end else if (cmd_i.wr_head) begin
      free_waddr = pos_q;
    end else begin
      free_waddr = hdr_idx;
    end
  end

  // header store, entry 0 lives in registers
  always_ff @(posedge clk_i) begin
    if (len_we && (len_waddr != '0)) begin
      len_mem[len_waddr] <= len_wdata;
    end
    if (free_we && (free_waddr != '0)) begin
      free_mem[free_waddr] <= free_wdata;
    end
    if (cmd_i.rd_en) begin
      len_rd_q  <= len_mem[pos_q];
      free_rd_q <= free_mem[pos_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len0_q  <= FullLen;
      free0_q <= 1'b1;
      pos_q   <= '0;
    end else begin
      if (cmd_i.accept && (in_data_i.func == ffba_pkg::FUNC_REINIT)) begin
        len0_q  <= FullLen;
        free0_q <= 1'b1;
      end else begin
        if (len_we && (len_waddr == '0)) begin
          len0_q <= len_wdata;
        end
        if (free_we && (free_waddr == '0)) begin
          free0_q <= free_wdata;
        end
      end
      if (cmd_i.accept) begin
        pos_q <= '0;
      end else if (cmd_i.advance) begin
        pos_q <= next_w[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      want_q       <= in_data_i.req_size;
      res_q.status <= ffba_pkg::STATUS_DONE;
      res_q.addr   <= '0;
    end else if (cmd_i.capture_ok) begin
      res_q.status <= ffba_pkg::STATUS_DONE;
      res_q.addr   <= ffba_pkg::FIELD_W'(pos_w + HdrW);
    end else if (cmd_i.capture_fail) begin
      res_q.status <= ffba_pkg::STATUS_NO_FIT;
      res_q.addr   <= '0;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_data_o = out_q;

endmodule

>>> rtl/core/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a byte arena with a header before each block.
//
//   channel  direction  payload            handshake
//   in       input      ffba_pkg::in_t     in_valid_i / in_stall_o
//   out      output     ffba_pkg::out_t    out_valid_o / out_stall_i
//
// free, reinit and unused ops: no walk, from accept straight to the hand-off
// allocate: a read and a check per header visited, then a tail write if split, a head
// write and the hand-off; a walk that finds no fit skips the write back
// entry 0 is held in flops, so reset needs no clearing pass
// one op in flight; a new beat is taken while the previous result waits
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
  parameter int unsigned ARENA_BYTES  = 4096,
  parameter int unsigned HEADER_BYTES = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ffba_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ffba_pkg::out_t out_data_o
);

  ffba_pkg::cmd_t  cmd;
  ffba_pkg::stat_t stat;

  ffba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (in_data_i.func),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ffba_datapath #(
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

>>> bench/first_fit_block_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_tb
// Self-checking bench for the first-fit block allocator. A short directed
// sequence covers the split, exact-fit, no-fit and trusted-free corner cases,
// then about 1400 random requests follow, mostly allocates of small blocks and
// frees of blocks handed out earlier, mixed with reinit, stray frees and
// unused ops. Every accepted request updates a shadow arena that yields the
// expected reply; replies are checked in order against it. Both channels idle
// in random bursts, the reply side holds off once for a long stretch, and the
// sender pauses once until every reply is in.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_tb;

  localparam int ARENA      = 4096;
  localparam int HDR        = 8;
  localparam int N_RANDOM   = 1160;
  localparam int LOOKAHEAD  = 4;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_AT    = 400;
  localparam int HOLD_LEN   = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  ffba_pkg::in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  ffba_pkg::out_t out_data_o;

  ffba_pkg::in_t  requests_todo[$];
  ffba_pkg::out_t replies_due[$];
  logic [11:0] live_blocks[$];

  logic [11:0] arena_len [0:ARENA-1];
  bit          arena_free[0:ARENA-1];

  int  n_errors = 0;
  int  in_beats = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  calm = 1'b0;
  int  idle_cycles = 0;

  first_fit_block_allocator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // walks the shadow arena and returns the reply the block owes for req
  function automatic ffba_pkg::out_t apply_request(ffba_pkg::in_t req);
    ffba_pkg::out_t res;
    int   pos;
    int   steps;
    int   want;
    int   len_v;
    bit   found;
    res        = '0;
    res.status = ffba_pkg::STATUS_DONE;
    case (req.func)
      ffba_pkg::FUNC_ALLOC: begin
        want  = req.req_size;
        pos   = 0;
        steps = 0;
        found = 1'b0;
        while (!found && pos + HDR <= ARENA && steps < ARENA) begin
          len_v = arena_len[pos];
          if (arena_free[pos] && len_v >= want) begin
            if (len_v > want + HDR) begin
              if (pos + HDR + want < ARENA) begin
                arena_len[pos + HDR + want]  = 12'(len_v - want - HDR);
                arena_free[pos + HDR + want] = 1'b1;
              end
              arena_len[pos] = 12'(want);
            end
            arena_free[pos] = 1'b0;
            found    = 1'b1;
            res.addr = 12'(pos + HDR);
            live_blocks.push_back(res.addr);
          end else begin
            pos   = pos + HDR + len_v;
            steps = steps + 1;
          end
        end
        if (!found) res.status = ffba_pkg::STATUS_NO_FIT;
      end
      ffba_pkg::FUNC_FREE: begin
        if (req.free_addr >= HDR) arena_free[req.free_addr - HDR] = 1'b1;
      end
      ffba_pkg::FUNC_REINIT: begin
        arena_len[0]  = 12'(ARENA - HDR);
        arena_free[0] = 1'b1;
        live_blocks.delete();
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    n_errors = n_errors + 1;
  endtask

  task automatic queue_request(ffba_pkg::func_e f, int size, int addr);
    ffba_pkg::in_t req;
    while (requests_todo.size() >= LOOKAHEAD) @(negedge clk_i);
    req.func      = f;
    req.req_size  = 12'(size);
    req.free_addr = 12'(addr);
    requests_todo.push_back(req);
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        replies_due.push_back(apply_request(in_data_i));
        in_beats <= in_beats + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 5);
          in_valid_i <= 1'b0;
        end else if (requests_todo.size() > 0) begin
          in_data_i  <= requests_todo.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // reply side stall, with one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_done && in_beats >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN - 1;
      out_stall_i <= 1'b1;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // reply monitor
  always @(posedge clk_i) begin
    ffba_pkg::out_t want_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (replies_due.size() == 0) begin
        report_mismatch("reply beat with nothing due, addr", out_data_o.addr, 0);
      end else begin
        want_res = replies_due.pop_front();
        if (out_data_o.status !== want_res.status)
          report_mismatch("status", out_data_o.status, want_res.status);
        if (out_data_o.addr !== want_res.addr)
          report_mismatch("addr", out_data_o.addr, want_res.addr);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int r;
    int k;
    int pick;
    int size;
    logic [11:0] addr;

    for (k = 0; k < ARENA; k++) begin
      arena_len[k]  = '0;
      arena_free[k] = 1'b0;
    end
    arena_len[0]  = 12'(ARENA - HDR);
    arena_free[0] = 1'b1;

    // directed corner cases
    queue_request(ffba_pkg::FUNC_ALLOC, 0, 0);          // zero-size split
    queue_request(ffba_pkg::FUNC_ALLOC, 4088, 4095);    // too large
    queue_request(ffba_pkg::FUNC_ALLOC, 4080, 0);       // exact fit
    queue_request(ffba_pkg::FUNC_ALLOC, 1, 0);          // walk runs off the end
    queue_request(ffba_pkg::FUNC_FREE, 0, 16);
    queue_request(ffba_pkg::FUNC_FREE, 4088, 16);       // double free
    queue_request(ffba_pkg::FUNC_FREE, 0, 7);           // below header
    queue_request(ffba_pkg::FUNC_FREE, 0, 0);
    queue_request(ffba_pkg::FUNC_NOP, 4088, 4095);
    queue_request(ffba_pkg::FUNC_REINIT, 0, 0);
    queue_request(ffba_pkg::FUNC_ALLOC, 4082, 0);       // near fit, unsplit
    queue_request(ffba_pkg::FUNC_REINIT, 4088, 4095);
    queue_request(ffba_pkg::FUNC_ALLOC, 4088, 0);
    queue_request(ffba_pkg::FUNC_ALLOC, 0, 0);
    queue_request(ffba_pkg::FUNC_REINIT, 0, 0);
    queue_request(ffba_pkg::FUNC_ALLOC, 4079, 0);       // leaves a 1-byte tail at the end
    queue_request(ffba_pkg::FUNC_ALLOC, 1, 0);
    queue_request(ffba_pkg::FUNC_ALLOC, 0, 0);
    queue_request(ffba_pkg::FUNC_FREE, 0, 4095);
    queue_request(ffba_pkg::FUNC_ALLOC, 0, 0);
    queue_request(ffba_pkg::FUNC_REINIT, 0, 0);
    queue_request(ffba_pkg::FUNC_ALLOC, 2048, 2047);
    queue_request(ffba_pkg::FUNC_ALLOC, 2048, 0);
    queue_request(ffba_pkg::FUNC_FREE, 0, 2056);        // trusted free inside a payload
    queue_request(ffba_pkg::FUNC_REINIT, 0, 0);

    for (k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM - 200) calm = 1'b1;
      if (k == N_RANDOM / 2) begin
        while (requests_todo.size() > 0 || in_valid_i || replies_due.size() > 0)
          @(negedge clk_i);
      end
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 19))
        0:       size = $urandom_range(0, 4088);
        1:       size = $urandom_range(4000, 4088);
        2, 3, 4: size = $urandom_range(33, 400);
        default: size = $urandom_range(0, 32);
      endcase
      if (k % 150 == 75) begin
        // a burst of allocates that aims to fill the arena
        repeat (30)
          queue_request(ffba_pkg::FUNC_ALLOC, $urandom_range(64, 200),
                        $urandom_range(0, 4095));
      end else if (r < 50) begin
        queue_request(ffba_pkg::FUNC_ALLOC, size, $urandom_range(0, 4095));
      end else if (r < 78) begin
        if (live_blocks.size() > 0) begin
          pick = $urandom_range(0, live_blocks.size() - 1);
          addr = live_blocks[pick];
          live_blocks.delete(pick);
          queue_request(ffba_pkg::FUNC_FREE, $urandom_range(0, 4088), addr);
        end else begin
          queue_request(ffba_pkg::FUNC_ALLOC, size, 0);
        end
      end else if (r < 82) begin
        queue_request(ffba_pkg::FUNC_REINIT, $urandom_range(0, 4088),
                      $urandom_range(0, 4095));
      end else if (r < 88) begin
        queue_request(ffba_pkg::FUNC_FREE, $urandom_range(0, 4088),
                      $urandom_range(0, 4095));
      end else if (r < 92) begin
        queue_request(ffba_pkg::FUNC_FREE, $urandom_range(0, 4088),
                      $urandom_range(0, HDR - 1));
      end else if (r < 96) begin
        queue_request(ffba_pkg::FUNC_NOP, $urandom_range(0, 4088),
                      $urandom_range(0, 4095));
      end else begin
        queue_request(ffba_pkg::FUNC_ALLOC, $urandom_range(4080, 4088),
                      $urandom_range(0, 4095));
      end
    end

    while (requests_todo.size() > 0 || in_valid_i || replies_due.size() > 0)
      @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
